// File: hw/rtl/rtph264_pkg.sv
// shared types and constants for the rtp h264 depacketizer
package rtph264_pkg;

  localparam int unsigned ClockRateW     = 20;
  localparam logic [19:0] ClockRateReset = 20'd90000;
  localparam int unsigned TsMsW          = 29;
  localparam logic [28:0] TsMax          = 29'h1FFF_FFFF;

  localparam logic [2:0] StNone      = 3'd0;
  localparam logic [2:0] StFragDrop  = 3'd1;
  localparam logic [2:0] StSeqGap    = 3'd2;
  localparam logic [2:0] StStapBad   = 3'd3;
  localparam logic [2:0] StFragOrder = 3'd4;

  localparam logic [1:0] KindNone   = 2'd0;
  localparam logic [1:0] KindSingle = 2'd1;
  localparam logic [1:0] KindFua    = 2'd2;
  localparam logic [1:0] KindStap   = 2'd3;

  localparam logic [4:0] NalFua  = 5'd28;
  localparam logic [4:0] NalStap = 5'd24;
  localparam logic [4:0] NalMax  = 5'd23;

  localparam logic [1:0] PhLenHi = 2'd0;
  localparam logic [1:0] PhLenLo = 2'd1;
  localparam logic [1:0] PhData  = 2'd2;

  // one result word
  typedef struct packed {
    logic       has_byte;
    logic [7:0] out_byte;
    logic       unit_end;
    logic       from_fragments;
    logic [2:0] status;
  } res_t;

  // controller to datapath
  typedef struct packed {
    logic div_start;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic        div_busy;
  } dp_sts_t;

endpackage

// File: hw/rtl/rtph264_div.sv
// timestamp to millisecond datapath: multiply by 1000 then restoring divide
module rtph264_div #(
  parameter int unsigned ClockRateW = rtph264_pkg::ClockRateW
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rtph264_pkg::dp_cmd_t       cmd_i,
  input  logic [31:0]                ts_i,
  input  logic [ClockRateW-1:0]      rate_i,
  output rtph264_pkg::dp_sts_t       sts_o,
  output logic [28:0]                ms_o
);
  localparam int unsigned NumW = 42;

  typedef enum logic [1:0] {
    PhMul,
    PhIter,
    PhDone
  } ph_e;

  logic [NumW-1:0]       num_q, num_d;
  logic [NumW-1:0]       quo_q, quo_d;
  logic [ClockRateW:0]   rem_q, rem_d;
  logic [ClockRateW-1:0] den_q, den_d;
  logic [5:0]            cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  ph_e                   ph_q, ph_d;
  logic [28:0]           ms_q, ms_d;
  logic [ClockRateW:0]   trial;
  logic [ClockRateW:0]   sh;

  always_comb begin
    num_d  = num_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    ph_d   = ph_q;
    ms_d   = ms_q;
    sh     = {rem_q[ClockRateW-1:0], num_q[NumW-1]};
    trial  = sh - {1'b0, den_q};
    if (cmd_i.div_start) begin
      num_d  = {10'd0, ts_i};
      den_d  = rate_i;
      busy_d = 1'b1;
      ph_d   = PhMul;
    end else if (busy_q) begin
      case (ph_q)
        PhMul: begin
          // times 1000 as 1024 - 16 - 8
          num_d = (num_q << 10) - (num_q << 4) - (num_q << 3);
          rem_d = '0;
          quo_d = '0;
          cnt_d = 6'(NumW);
          ph_d  = PhIter;
        end
        PhIter: begin
          num_d = {num_q[NumW-2:0], 1'b0};
          if (sh >= {1'b0, den_q}) begin
            rem_d = trial;
            quo_d = {quo_q[NumW-2:0], 1'b1};
          end else begin
            rem_d = sh;
            quo_d = {quo_q[NumW-2:0], 1'b0};
          end
          cnt_d = cnt_q - 6'd1;
          if (cnt_q == 6'd1) ph_d = PhDone;
        end
        default: begin
          if (den_q == '0 || quo_q > NumW'(rtph264_pkg::TsMax)) begin
            ms_d = rtph264_pkg::TsMax;
          end else begin
            ms_d = quo_q[28:0];
          end
          busy_d = 1'b0;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ph_q   <= PhMul;
      cnt_q  <= '0;
      ms_q   <= '0;
      num_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      den_q  <= '0;
    end else begin
      busy_q <= busy_d;
      ph_q   <= ph_d;
      cnt_q  <= cnt_d;
      ms_q   <= ms_d;
      num_q  <= num_d;
      quo_q  <= quo_d;
      rem_q  <= rem_d;
      den_q  <= den_d;
    end
  end

  assign sts_o.div_busy = busy_q;
  assign ms_o           = ms_q;
endmodule

// File: hw/rtl/rtph264_ctrl.sv
// packet parsing controller: decodes one byte into up to six results
module rtph264_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_fire_i,
  input  logic [7:0]           b_i,
  input  logic                 first_i,
  input  logic                 last_i,
  input  logic [15:0]          seq_i,
  output rtph264_pkg::dp_cmd_t cmd_o,
  output rtph264_pkg::res_t    res_o [6],
  output logic [2:0]           cnt_o,
  output logic                 new_ts_o
);
  logic        seq_seen_q, seq_seen_d;
  logic [15:0] last_seq_q, last_seq_d;
  logic        frag_q, frag_d;
  logic [1:0]  kind_q, kind_d;
  logic        skip_q, skip_d;
  logic [1:0]  idx_q, idx_d;
  logic [7:0]  ind_q, ind_d;
  logic        fend_q, fend_d;
  logic [15:0] rem_q, rem_d;
  logic [1:0]  ph_q, ph_d;
  logic        bad_q, bad_d;
  logic [1:0]  idx;
  logic [4:0]  t;
  logic [15:0] remv;
  rtph264_pkg::res_t r [6];
  logic [2:0]  n;
  logic        newts;

  function automatic rtph264_pkg::res_t mk(logic h, logic [7:0] v, logic e, logic f,
                                           logic [2:0] s);
    rtph264_pkg::res_t x;
    x.has_byte = h;
    x.out_byte = h ? v : 8'd0;
    x.unit_end = e;
    x.from_fragments = f;
    x.status = s;
    return x;
  endfunction

  always_comb begin
    seq_seen_d = seq_seen_q; last_seq_d = last_seq_q; frag_d = frag_q;
    kind_d = kind_q; skip_d = skip_q; idx_d = idx_q; ind_d = ind_q;
    fend_d = fend_q; rem_d = rem_q; ph_d = ph_q; bad_d = bad_q;
    for (int i = 0; i < 6; i++) r[i] = '0;
    n = 3'd0; newts = 1'b0; idx = idx_q; t = b_i[4:0]; remv = '0;
    if (in_fire_i) begin
      if (kind_q == rtph264_pkg::KindNone && !skip_q) begin
        if (first_i) begin
          newts = 1'b1;
          idx_d = 2'd0; bad_d = 1'b0; ph_d = rtph264_pkg::PhLenHi; rem_d = '0;
          if (seq_seen_q && seq_i != last_seq_q + 16'd1) begin
            frag_d = 1'b0; fend_d = 1'b0; last_seq_d = seq_i;
            r[n] = mk(1'b0, 8'h00, 1'b0, 1'b0, rtph264_pkg::StSeqGap); n = n + 3'd1;
            kind_d = rtph264_pkg::KindNone; skip_d = 1'b1;
          end else begin
            seq_seen_d = 1'b1; last_seq_d = seq_i;
            if (t >= 5'd1 && t <= rtph264_pkg::NalMax) kind_d = rtph264_pkg::KindSingle;
            else if (t == rtph264_pkg::NalFua) kind_d = rtph264_pkg::KindFua;
            else if (t == rtph264_pkg::NalStap) kind_d = rtph264_pkg::KindStap;
            else begin kind_d = rtph264_pkg::KindNone; skip_d = 1'b1; end
          end
        end
      end
      if (newts || kind_q != rtph264_pkg::KindNone || skip_q) begin
        idx = newts ? 2'd0 : idx_q;
        case (kind_d)
          rtph264_pkg::KindSingle: begin
            if (idx == 2'd0) begin
              r[n]   = mk(1'b1, 8'h00, 1'b0, 1'b0, rtph264_pkg::StNone);
              r[n+1] = mk(1'b1, 8'h00, 1'b0, 1'b0, rtph264_pkg::StNone);
              r[n+2] = mk(1'b1, 8'h00, 1'b0, 1'b0, rtph264_pkg::StNone);
              r[n+3] = mk(1'b1, 8'h01, 1'b0, 1'b0, rtph264_pkg::StNone);
              n = n + 3'd4;
            end
            r[n] = mk(1'b1, b_i, last_i, 1'b0, rtph264_pkg::StNone); n = n + 3'd1;
          end
          rtph264_pkg::KindFua: begin
            if (idx == 2'd0) ind_d = b_i;
            else if (idx == 2'd1) begin
              if (b_i[7] && b_i[6]) begin
                frag_d = 1'b0; fend_d = 1'b0;
                r[n] = mk(1'b0, 8'h00, 1'b0, 1'b0, rtph264_pkg::StFragOrder);
                n = n + 3'd1;
                kind_d = rtph264_pkg::KindNone; skip_d = 1'b1;
              end else if (b_i[7]) begin
                if (frag_q) begin
                  r[n] = mk(1'b0, 8'h00, 1'b0, 1'b0, rtph264_pkg::StFragDrop);
                  n = n + 3'd1;
                end
                frag_d = 1'b1; fend_d = 1'b0;
                r[n]   = mk(1'b1, 8'h00, 1'b0, 1'b1, rtph264_pkg::StNone);
                r[n+1] = mk(1'b1, 8'h00, 1'b0, 1'b1, rtph264_pkg::StNone);
                r[n+2] = mk(1'b1, 8'h00, 1'b0, 1'b1, rtph264_pkg::StNone);
                r[n+3] = mk(1'b1, 8'h01, 1'b0, 1'b1, rtph264_pkg::StNone);
                r[n+4] = mk(1'b1, (ind_q & 8'he0) | {3'd0, b_i[4:0]}, 1'b0, 1'b1,
                            rtph264_pkg::StNone);
                n = n + 3'd5;
              end else if (b_i[6]) begin
                if (!frag_q) begin
                  fend_d = 1'b0;
                  r[n] = mk(1'b0, 8'h00, 1'b0, 1'b0, rtph264_pkg::StFragOrder);
                  n = n + 3'd1;
                  kind_d = rtph264_pkg::KindNone; skip_d = 1'b1;
                end else fend_d = 1'b1;
              end else if (!frag_q) begin
                kind_d = rtph264_pkg::KindNone; skip_d = 1'b1;
              end
            end else if (frag_q) begin
              r[n] = mk(1'b1, b_i, last_i && fend_q, 1'b1, rtph264_pkg::StNone);
              n = n + 3'd1;
            end
          end
          rtph264_pkg::KindStap: begin
            if (idx != 2'd0) begin
              case (ph_d)
                rtph264_pkg::PhLenHi: begin
                  rem_d = {b_i, 8'd0}; ph_d = rtph264_pkg::PhLenLo;
                end
                rtph264_pkg::PhLenLo: begin
                  rem_d = {rem_q[15:8], b_i};
                  if (rem_d == '0 || last_i) begin
                    bad_d = 1'b1; ph_d = rtph264_pkg::PhLenHi;
                  end else begin
                    r[n]   = mk(1'b1, 8'h00, 1'b0, 1'b0, rtph264_pkg::StNone);
                    r[n+1] = mk(1'b1, 8'h00, 1'b0, 1'b0, rtph264_pkg::StNone);
                    r[n+2] = mk(1'b1, 8'h00, 1'b0, 1'b0, rtph264_pkg::StNone);
                    r[n+3] = mk(1'b1, 8'h01, 1'b0, 1'b0, rtph264_pkg::StNone);
                    n = n + 3'd4; ph_d = rtph264_pkg::PhData;
                  end
                end
                default: begin
                  remv = rem_q - 16'd1; rem_d = remv;
                  r[n] = mk(1'b1, b_i, (remv == '0) || last_i, 1'b0, rtph264_pkg::StNone);
                  n = n + 3'd1;
                  if (remv == '0) ph_d = rtph264_pkg::PhLenHi;
                end
              endcase
            end
          end
          default: ;
        endcase
        if (last_i) begin
          if (kind_d == rtph264_pkg::KindFua && frag_d && fend_d) begin
            if (idx == 2'd1) begin
              r[n] = mk(1'b0, 8'h00, 1'b1, 1'b1, rtph264_pkg::StNone); n = n + 3'd1;
            end
            frag_d = 1'b0; fend_d = 1'b0;
          end else if (kind_d == rtph264_pkg::KindStap) begin
            if (idx <= 2'd2 || ph_d != rtph264_pkg::PhLenHi || bad_d) begin
              r[n] = mk(1'b0, 8'h00, 1'b0, 1'b0, rtph264_pkg::StStapBad); n = n + 3'd1;
            end
          end
          kind_d = rtph264_pkg::KindNone; skip_d = 1'b0; idx_d = 2'd0;
          ph_d = rtph264_pkg::PhLenHi; rem_d = '0; bad_d = 1'b0;
        end else begin
          idx_d = (idx < 2'd3) ? idx + 2'd1 : 2'd3;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_seen_q <= 1'b0; last_seq_q <= '0; frag_q <= 1'b0;
      kind_q <= rtph264_pkg::KindNone; skip_q <= 1'b0; idx_q <= '0; ind_q <= '0;
      fend_q <= 1'b0; rem_q <= '0; ph_q <= rtph264_pkg::PhLenHi; bad_q <= 1'b0;
    end else begin
      seq_seen_q <= seq_seen_d; last_seq_q <= last_seq_d; frag_q <= frag_d;
      kind_q <= kind_d; skip_q <= skip_d; idx_q <= idx_d; ind_q <= ind_d;
      fend_q <= fend_d; rem_q <= rem_d; ph_q <= ph_d; bad_q <= bad_d;
    end
  end

  assign cmd_o.div_start = newts;
  assign res_o    = r;
  assign cnt_o    = n;
  assign new_ts_o = newts;
endmodule

// File: hw/rtl/rtp_h264_depacketizer.sv
// top level of the rtp h264 depacketizer
//  channel | dir | handshake               | payload
//  s_axis  | in  | s_axis_tvalid/tready    | data byte, first/last flags, seq, timestamp
//  m_axis  | out | m_axis_tvalid/tready    | stream byte, flags, ms timestamp, status
//  cfg     | in  | cfg_valid_i/cfg_ready_o | clock_rate
// an input word is decoded combinationally; its results (up to six) go out one per
// cycle while m_axis_tready is high and the divider is idle
// after a packet's first word the divider runs, stalling both sides
// reset clears all parser state and sets clock_rate to 90000
// the input stalls while results are pending or the divider runs
module rtp_h264_depacketizer #(
  parameter int unsigned ClockRateW = rtph264_pkg::ClockRateW
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [55:0]           s_axis_tdata,  // data_byte, seq_number, rtp_timestamp
  input  logic                  s_axis_tlast,  // last_of_packet
  input  logic                  s_axis_tuser,  // first_of_packet
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [39:0]           m_axis_tdata,  // out_byte, timestamp_ms, status
  output logic                  m_axis_tlast,  // last_in_run
  output logic [2:0]            m_axis_tuser,  // has_byte, unit_end, from_fragments
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [ClockRateW-1:0] cfg_data_i
);
  logic [ClockRateW-1:0] rate_q;
  rtph264_pkg::res_t     res [6];
  rtph264_pkg::res_t     buf_q [6];
  logic [2:0]            cnt, n_q, rd_q;
  logic                  newts, fire, hold_q;
  rtph264_pkg::dp_cmd_t  cmd;
  rtph264_pkg::dp_sts_t  sts;
  logic [28:0]           ms;
  rtph264_pkg::res_t     cur;

  assign s_axis_tready = (n_q == 3'd0) && !sts.div_busy && !hold_q;
  assign fire          = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  rtph264_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_fire_i(fire), .b_i(s_axis_tdata[7:0]),
    .first_i(s_axis_tuser), .last_i(s_axis_tlast), .seq_i(s_axis_tdata[23:8]),
    .cmd_o(cmd), .res_o(res), .cnt_o(cnt), .new_ts_o(newts)
  );

  rtph264_div #(.ClockRateW(ClockRateW)) u_div (
    .clk_i, .rst_ni, .cmd_i(cmd), .ts_i(s_axis_tdata[55:24]), .rate_i(rate_q),
    .sts_o(sts), .ms_o(ms)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q <= ClockRateW'(rtph264_pkg::ClockRateReset);
      n_q    <= '0;
      rd_q   <= '0;
      hold_q <= 1'b0;
    end else begin
      if (cfg_valid_i) rate_q <= cfg_data_i;
      hold_q <= fire && newts;
      if (fire) begin
        n_q  <= cnt;
        rd_q <= '0;
      end else if (m_axis_tvalid && m_axis_tready) begin
        if (rd_q + 3'd1 == n_q) begin
          n_q  <= '0;
          rd_q <= '0;
        end else begin
          rd_q <= rd_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) buf_q <= res;
  end

  assign cur           = buf_q[rd_q];
  assign m_axis_tvalid = (n_q != 3'd0) && !sts.div_busy && !hold_q;
  assign m_axis_tlast  = (rd_q + 3'd1 == n_q);
  assign m_axis_tuser  = {cur.from_fragments, cur.unit_end, cur.has_byte};
  assign m_axis_tdata  = {cur.status, (cur.unit_end ? ms : 29'd0), cur.out_byte};
endmodule
